FILE: rtl/nsuv_pkg.sv
// ---------------------------------------------------------------------------
// nsuv_pkg
// Shared types, constants and functions for the spherical UV mapping core.
// ---------------------------------------------------------------------------
package nsuv_pkg;

	localparam int CORDIC_STAGES = 16;
	localparam int SQRT_STAGES   = 23;	// one root bit per cell
	localparam int LW  = 28;		// CORDIC vector lane width
	localparam int AW  = 34;		// angle width, 2^-32 turn units
	localparam int NW  = 46;		// radicand width
	localparam int QW  = 23;		// root width
	localparam int RW  = 26;		// partial remainder width
	localparam int SHW = 5;		// stage index width
	localparam int DW  = 36;		// coordinate difference width

	localparam logic signed [AW-1:0] HALF_TURN = AW'(64'sd2147483648);

	typedef struct packed {
		logic signed [LW-1:0] a;
		logic signed [LW-1:0] b;
		logic signed [AW-1:0] ang;
		logic                 zero;
	} lane_t;

	typedef struct packed {
		lane_t               u;
		logic signed [15:0]  y;
		logic                last;
	} side_t;

	typedef struct packed {
		logic [NW-1:0] n;
		logic [RW-1:0] rem;
		logic [QW-1:0] root;
		side_t         side;
	} sq_t;

	// atan(2^-i) as a fraction of a full turn, 2^-32 units
	function automatic logic signed [AW-1:0] atan_tab(input logic [SHW-1:0] idx);
		logic signed [AW-1:0] r;
		unique case (idx)
			5'd0:  r = AW'(536870912);
			5'd1:  r = AW'(316933406);
			5'd2:  r = AW'(167458907);
			5'd3:  r = AW'(85004756);
			5'd4:  r = AW'(42667331);
			5'd5:  r = AW'(21354465);
			5'd6:  r = AW'(10679838);
			5'd7:  r = AW'(5340245);
			5'd8:  r = AW'(2670163);
			5'd9:  r = AW'(1335087);
			5'd10: r = AW'(667544);
			5'd11: r = AW'(333772);
			5'd12: r = AW'(166886);
			5'd13: r = AW'(83443);
			5'd14: r = AW'(41722);
			5'd15: r = AW'(20861);
			5'd16: r = AW'(10430);
			5'd17: r = AW'(5215);
			5'd18: r = AW'(2608);
			5'd19: r = AW'(1304);
			5'd20: r = AW'(652);
			5'd21: r = AW'(326);
			5'd22: r = AW'(163);
			5'd23: r = AW'(81);
			default: r = '0;
		endcase
		return r;
	endfunction

	// fold the left half plane onto the right one before the rotations
	function automatic lane_t lane_init(input logic signed [LW-1:0] a,
			input logic signed [LW-1:0] b);
		lane_t l;
		l.zero = (a == '0) && (b == '0);
		if (a < 0) begin
			l.a   = -a;
			l.b   = -b;
			l.ang = (b >= 0) ? HALF_TURN : -HALF_TURN;
		end else begin
			l.a   = a;
			l.b   = b;
			l.ang = '0;
		end
		return l;
	endfunction

	// round half up to Q0.16 and saturate
	function automatic logic [15:0] to_q16(input logic signed [DW-1:0] d);
		logic signed [DW-1:0] q;
		logic [15:0] r;
		q = d + DW'(32768);
		if (q < 0)
			r = '0;
		else if (q[DW-2:32] != '0)
			r = '1;
		else
			r = q[31:16];
		return r;
	endfunction

endpackage

FILE: rtl/normal_spherical_uv_map_core.sv
// ---------------------------------------------------------------------------
// normal_spherical_uv_map_core
// Maps a Q1.14 vertex normal to spherical texture coordinates (Q0.16).
// ---------------------------------------------------------------------------
// Input channel: normal_x/y/z, last_vertex with in_valid/in_ready.
// Output channel: tex_u, tex_v, last_out with out_valid/out_ready.
// One word is taken per cycle while in_ready is high, and every word yields
// exactly one result word. An accepted word passes two input stages, a chain
// of 23 square-root cells (one root bit each) for cos(asin(y)), then 16 CORDIC
// cells per angle running two lanes side by side, then the output register.
// Throughput is one word per clock while in_ready is high, set by the cell
// chain. When the receiver stalls, one more result drains into a skid register
// and then the whole chain holds; in_ready drops while the skid register is
// full. Reset clears all valid flags; the chain then accepts immediately.
// ---------------------------------------------------------------------------
module normal_spherical_uv_map_core import nsuv_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic               last_vertex,
	input  logic               in_valid,
	output logic               in_ready,
	output logic [15:0]        tex_u,
	output logic [15:0]        tex_v,
	output logic               last_out,
	output logic               out_valid,
	input  logic               out_ready
);

	logic en;

	logic               vld_s1, vld_s2;
	lane_t              u_s1;
	logic signed [15:0] y_s1;
	logic               last_s1;
	sq_t                sq_s2;

	logic signed [15:0] y_cl;
	logic signed [31:0] ysq;
	logic [28:0]        diff;

	sq_t   sq_c [SQRT_STAGES];
	logic  vld_sq [SQRT_STAGES];
	lane_t v_init;
	lane_t u_c [CORDIC_STAGES];
	lane_t v_c [CORDIC_STAGES];
	logic  vld_cd [CORDIC_STAGES];
	logic  last_cd [CORDIC_STAGES];

	logic signed [AW-1:0] ang_u;
	logic [15:0]          res_u, res_v;
	logic                 arrive;

	logic        out_vld_q, skid_vld_q;
	logic [15:0] out_u_q, out_v_q, skid_u_q, skid_v_q;
	logic        out_last_q, skid_last_q;

	assign en       = !skid_vld_q;
	assign in_ready = en;

	// clamp y to plus or minus one
	always_comb begin
		if (normal_y > 16'sd16384)
			y_cl = 16'sd16384;
		else if (normal_y < -16'sd16384)
			y_cl = -16'sd16384;
		else
			y_cl = normal_y;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			u_s1    <= lane_init({{4{normal_x[15]}}, normal_x, 8'b0},
			                     {{4{normal_z[15]}}, normal_z, 8'b0});
			y_s1    <= y_cl;
			last_s1 <= last_vertex;
		end
	end

	// radicand (1 - y^2) scaled so the root lands in Q.22
	assign ysq  = y_s1 * y_s1;
	assign diff = 29'h1000_0000 - ysq[28:0];

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s2.n         <= {1'b0, diff, 16'b0};
			sq_s2.rem       <= '0;
			sq_s2.root      <= '0;
			sq_s2.side.u    <= u_s1;
			sq_s2.side.y    <= y_s1;
			sq_s2.side.last <= last_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
		end
	end

	for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sq
		if (i == 0) begin : g_first
			nsuv_sqrt_cell u_cell (.clk, .en, .d_in(sq_s2), .d_out(sq_c[i]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_sq[i] <= 1'b0;
				else if (en)
					vld_sq[i] <= vld_s2;
			end
		end else begin : g_next
			nsuv_sqrt_cell u_cell (.clk, .en, .d_in(sq_c[i-1]), .d_out(sq_c[i]));
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_sq[i] <= 1'b0;
				else if (en)
					vld_sq[i] <= vld_sq[i-1];
			end
		end
	end

	// asin(y) as atan2(y, sqrt(1 - y^2))
	assign v_init = lane_init({{(LW-QW){1'b0}}, sq_c[SQRT_STAGES-1].root},
	                          {{4{sq_c[SQRT_STAGES-1].side.y[15]}},
	                           sq_c[SQRT_STAGES-1].side.y, 8'b0});

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cd
		if (i == 0) begin : g_first
			nsuv_cordic_cell u_ucell (.clk, .en, .stage(SHW'(i)),
				.l_in(sq_c[SQRT_STAGES-1].side.u), .l_out(u_c[i]));
			nsuv_cordic_cell u_vcell (.clk, .en, .stage(SHW'(i)),
				.l_in(v_init), .l_out(v_c[i]));
			always_ff @(posedge clk) begin
				if (en)
					last_cd[i] <= sq_c[SQRT_STAGES-1].side.last;
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_cd[i] <= 1'b0;
				else if (en)
					vld_cd[i] <= vld_sq[SQRT_STAGES-1];
			end
		end else begin : g_next
			nsuv_cordic_cell u_ucell (.clk, .en, .stage(SHW'(i)),
				.l_in(u_c[i-1]), .l_out(u_c[i]));
			nsuv_cordic_cell u_vcell (.clk, .en, .stage(SHW'(i)),
				.l_in(v_c[i-1]), .l_out(v_c[i]));
			always_ff @(posedge clk) begin
				if (en)
					last_cd[i] <= last_cd[i-1];
			end
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n)
					vld_cd[i] <= 1'b0;
				else if (en)
					vld_cd[i] <= vld_cd[i-1];
			end
		end
	end

	// a zero direction gives angle zero
	assign ang_u = u_c[CORDIC_STAGES-1].zero ? '0 : u_c[CORDIC_STAGES-1].ang;
	assign res_u = to_q16(DW'(HALF_TURN) - DW'(ang_u));
	assign res_v = to_q16(DW'(HALF_TURN) - (DW'(v_c[CORDIC_STAGES-1].ang) <<< 1));
	assign arrive = vld_cd[CORDIC_STAGES-1] && en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || out_ready) begin
			out_vld_q  <= skid_vld_q || arrive;
			skid_vld_q <= 1'b0;
		end else if (arrive) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || out_ready) begin
			if (skid_vld_q) begin
				out_u_q    <= skid_u_q;
				out_v_q    <= skid_v_q;
				out_last_q <= skid_last_q;
			end else begin
				out_u_q    <= res_u;
				out_v_q    <= res_v;
				out_last_q <= last_cd[CORDIC_STAGES-1];
			end
		end else if (arrive) begin
			// hold the drained word until the output frees up
			skid_u_q    <= res_u;
			skid_v_q    <= res_v;
			skid_last_q <= last_cd[CORDIC_STAGES-1];
		end
	end

	assign out_valid = out_vld_q;
	assign tex_u     = out_u_q;
	assign tex_v     = out_v_q;
	assign last_out  = out_last_q;

endmodule

FILE: rtl/nsuv_sqrt_cell.sv
// ---------------------------------------------------------------------------
// nsuv_sqrt_cell
// One restoring square-root step: one root bit per cycle while en is high.
// ---------------------------------------------------------------------------
module nsuv_sqrt_cell import nsuv_pkg::*; (
	input  logic clk,
	input  logic en,
	input  sq_t  d_in,
	output sq_t  d_out
);

	logic [RW-1:0] rem_sh;
	logic [RW-1:0] trial;
	sq_t           nxt;

	always_comb begin
		rem_sh   = {d_in.rem[RW-3:0], d_in.n[NW-1:NW-2]};
		trial    = {1'b0, d_in.root, 2'b01};
		nxt.n    = {d_in.n[NW-3:0], 2'b00};
		nxt.side = d_in.side;
		if (rem_sh >= trial) begin
			nxt.rem  = rem_sh - trial;
			nxt.root = {d_in.root[QW-2:0], 1'b1};
		end else begin
			nxt.rem  = rem_sh;
			nxt.root = {d_in.root[QW-2:0], 1'b0};
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			d_out <= nxt;
	end

endmodule

FILE: rtl/nsuv_cordic_cell.sv
// ---------------------------------------------------------------------------
// nsuv_cordic_cell
// One vectoring CORDIC rotation: drive b toward zero, accumulate the angle.
// ---------------------------------------------------------------------------
module nsuv_cordic_cell import nsuv_pkg::*; (
	input  logic           clk,
	input  logic           en,
	input  logic [SHW-1:0] stage,
	input  lane_t          l_in,
	output lane_t          l_out
);

	logic signed [LW-1:0] da;
	logic signed [LW-1:0] db;
	logic signed [AW-1:0] step;
	lane_t                nxt;

	always_comb begin
		da       = l_in.b >>> stage;
		db       = l_in.a >>> stage;
		step     = atan_tab(stage);
		nxt.zero = l_in.zero;
		if (l_in.b >= 0) begin
			nxt.a   = l_in.a + da;
			nxt.b   = l_in.b - db;
			nxt.ang = l_in.ang + step;
		end else begin
			nxt.a   = l_in.a - da;
			nxt.b   = l_in.b + db;
			nxt.ang = l_in.ang - step;
		end
	end

	always_ff @(posedge clk) begin
		if (en)
			l_out <= nxt;
	end

endmodule

FILE: rtl/nsuv_checker.sv
// ---------------------------------------------------------------------------
// nsuv_checker
// Port-level checks for the spherical UV mapping core.
// ---------------------------------------------------------------------------
module nsuv_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_ready,
	input logic [15:0] tex_u,
	input logic [15:0] tex_v,
	input logic        last_out,
	input logic        out_valid,
	input logic        out_ready
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("out_valid dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(tex_u) && $stable(tex_v) && $stable(last_out))
		else $error("result word changed while stalled");

	a_ready_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input blocked with no result pending");

	a_ready_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input blocked without an output stall");

endmodule

bind normal_spherical_uv_map_core nsuv_checker u_nsuv_checker (
	.clk, .arst_n, .in_ready, .tex_u, .tex_v, .last_out, .out_valid, .out_ready
);

FILE: test/normal_spherical_uv_map_core_check.sv
// ---------------------------------------------------------------------------
// normal_spherical_uv_map_core_check
// Watches both channels of the UV mapping core, predicts tex_u/tex_v/last_out
// for every accepted normal with a bit-exact CORDIC model and compares results
// in order against the predictions.
// ---------------------------------------------------------------------------
module normal_spherical_uv_map_core_check (
	input  logic               clk,
	input  logic               arst_n,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic signed [15:0] normal_z,
	input  logic               last_vertex,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [15:0]        tex_u,
	input  logic [15:0]        tex_v,
	input  logic               last_out,
	input  logic               out_valid,
	input  logic               out_ready,
	output int                 errors,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct {
		logic [15:0] u;
		logic [15:0] v;
		logic        last;
	} uv_t;

	localparam longint TURN_HALF = 64'sd2147483648;
	localparam int     STAGES    = 16;

	longint turn_step [24] = '{
		536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
		10679838, 5340245, 2670163, 1335087, 667544, 333772,
		166886, 83443, 41722, 20861, 10430, 5215,
		2608, 1304, 652, 326, 163, 81};

	uv_t uv_queue [$];

	// arithmetic shift floors for negative values in SystemVerilog
	function automatic longint vector_angle(longint b, longint a);
		longint ang, da, db;
		ang = 0;
		if (a == 0 && b == 0)
			return 0;
		if (a < 0) begin
			ang = (b >= 0) ? TURN_HALF : -TURN_HALF;
			a = -a;
			b = -b;
		end
		for (int i = 0; i < STAGES; i++) begin
			da = b >>> i;
			db = a >>> i;
			if (b >= 0) begin
				a += da;
				b -= db;
				ang += turn_step[i];
			end else begin
				a -= da;
				b += db;
				ang -= turn_step[i];
			end
		end
		return ang;
	endfunction

	function automatic longint root_floor(longint n);
		longint r, lo, hi, m;
		lo = 0;
		hi = 64'd3037000499;
		while (lo < hi) begin
			m = (lo + hi + 1) / 2;
			if (m * m <= n)
				lo = m;
			else
				hi = m - 1;
		end
		r = lo;
		return r;
	endfunction

	function automatic logic [15:0] round_q16(longint d);
		longint q;
		q = d + 32768;
		if (q < 0)
			return 16'd0;
		q = q / 65536;
		if (q > 65535)
			return 16'hFFFF;
		return q[15:0];
	endfunction

	function automatic uv_t map_normal(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic lst);
		uv_t r;
		longint nx, ny, nz, az, as, c;
		nx = x;
		ny = y;
		nz = z;
		if (ny > 16384)
			ny = 16384;
		if (ny < -16384)
			ny = -16384;
		az = vector_angle(nz * 256, nx * 256);
		c = root_floor((64'd268435456 - ny * ny) << 16);
		as = vector_angle(ny * 256, c);
		r.u = round_q16(TURN_HALF - az);
		r.v = round_q16(TURN_HALF - 2 * as);
		r.last = lst;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		uv_t e;
		int  bad;
		bad = 0;
		if (!arst_n) begin
			errors  <= 0;
			pending <= 0;
		end else begin
			if (in_valid && in_ready)
				uv_queue.insert(uv_queue.size(),
					map_normal(normal_x, normal_y, normal_z, last_vertex));
			if (out_valid && out_ready) begin
				if (uv_queue.size() == 0) begin
					$error("unexpected result word u=%0d v=%0d", tex_u, tex_v);
					bad++;
				end else begin
					e = uv_queue.pop_front();
					if (tex_u !== e.u) begin
						$error("tex_u expected %0d actual %0d", e.u, tex_u);
						bad++;
					end
					if (tex_v !== e.v) begin
						$error("tex_v expected %0d actual %0d", e.v, tex_v);
						bad++;
					end
					if (last_out !== e.last) begin
						$error("last_out expected %0d actual %0d", e.last, last_out);
						bad++;
					end
				end
			end
			errors  <= errors + bad;
			pending <= uv_queue.size();
		end
	end

endmodule

FILE: test/normal_spherical_uv_map_core_test.sv
// ---------------------------------------------------------------------------
// normal_spherical_uv_map_core_test
// Drives directed and random normals into the UV mapping core under several
// idle and stall mixes, including one long output hold-off, and reports.
// ---------------------------------------------------------------------------
module normal_spherical_uv_map_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DIRECTED = 20;
	localparam int RANDOM   = 800;
	localparam int LIMIT    = 400000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic signed [15:0] normal_x = '0;
	logic signed [15:0] normal_y = '0;
	logic signed [15:0] normal_z = '0;
	logic               last_vertex = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [15:0]        tex_u;
	logic [15:0]        tex_v;
	logic               last_out;
	logic               out_valid;
	logic               out_ready = 1'b0;
	int                 errors;
	int                 pending;
	int                 send_idle = 0;
	int                 recv_stall = 0;
	bit                 hold_off = 1'b0;
	int                 cycles = 0;

	logic signed [15:0] dir_x [DIRECTED] = '{0, 16384, -16384, 0, 0, 0, 0, -16384, 32767,
		-32768, 16384, -16384, 11585, -11585, 100, -1, 0, 5000, -32768, 32767};
	logic signed [15:0] dir_y [DIRECTED] = '{0, 0, 0, 16384, -16384, 32767, -32768, 0,
		16383, -16383, 20000, -20000, 8192, -8192, 1, -1, 16384, 0, 32767, -32768};
	logic signed [15:0] dir_z [DIRECTED] = '{0, 0, 0, 0, 0, 0, 0, 0, 32767, -32768,
		16384, -16384, 11585, 11585, 0, 0, 16384, -16384, -1, 32767};

	always #5 clk = ~clk;

	normal_spherical_uv_map_core uut (.*);

	normal_spherical_uv_map_core_check check (.*);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// receiver: random stalls, or a fixed hold-off when asked
	always @(posedge clk) begin
		if (hold_off)
			out_ready <= 1'b0;
		else
			out_ready <= ($urandom_range(99) >= recv_stall);
	end

	// valid stays up between back-to-back words; drop it only while idling
	task automatic send_normal(logic signed [15:0] x, logic signed [15:0] y,
			logic signed [15:0] z, logic lst);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		normal_x <= x;
		normal_y <= y;
		normal_z <= z;
		last_vertex <= lst;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	function automatic logic signed [15:0] pick_comp();
		case ($urandom_range(3))
			0: return 16'($urandom);
			1: return 16'($signed($urandom_range(32768)) - 16384);
			2: return $urandom_range(1) ? 16'sd16384 : -16'sd16384;
			default: return 16'($signed($urandom_range(64)) - 32);
		endcase
	endfunction

	initial begin
		int mode;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		for (int i = 0; i < DIRECTED; i++)
			send_normal(dir_x[i], dir_y[i], dir_z[i], i[0]);
		// long hold-off so the pipe fills and input stalls
		hold_off = 1'b1;
		fork
			begin
				repeat (200) @(posedge clk);
				hold_off = 1'b0;
			end
			for (int i = 0; i < 80; i++)
				send_normal(pick_comp(), pick_comp(), pick_comp(), 1'($urandom));
		join
		for (int i = 0; i < RANDOM; i++) begin
			if (i % 100 == 0) begin
				mode = (i / 100) % 4;
				send_idle  = (mode == 1) ? 62 : (mode == 3) ? 17 : 0;
				recv_stall = (mode == 2) ? 62 : (mode == 3) ? 17 : 0;
			end
			send_normal(pick_comp(), pick_comp(), pick_comp(), 1'($urandom));
		end
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: normal_spherical_uv_map_core.f
rtl/nsuv_pkg.sv
rtl/nsuv_sqrt_cell.sv
rtl/nsuv_cordic_cell.sv
rtl/normal_spherical_uv_map_core.sv
rtl/nsuv_checker.sv
test/normal_spherical_uv_map_core_check.sv
test/normal_spherical_uv_map_core_test.sv
